// ----- hdl/soa_pkg.sv -----
// Package for the slab object allocator: sizes, list tags, status codes.
// Used by every module under hdl; depends on nothing.
package soa_pkg;
   localparam int NUM_SLABS   = 16;
   localparam int MAX_OBJECTS = 64;
   localparam int SLAB_W      = $clog2(NUM_SLABS);
   localparam int OBJ_W       = $clog2(MAX_OBJECTS);
   localparam int LINK_W      = SLAB_W + 1;
   localparam int CAP_W       = 7;
   localparam int CNT_W       = OBJ_W + 1;
   localparam int ADDR_W      = SLAB_W + OBJ_W;
   localparam logic [LINK_W-1:0] NULL_CODE = LINK_W'(NUM_SLABS);

   typedef enum logic [1:0] {
      TAG_NONE, TAG_EMPTY, TAG_PARTIAL, TAG_FULL
   } tag_type;

   typedef enum logic [1:0] {
      ST_OK, ST_NOMEM, ST_NOTFOUND, ST_DOUBLE
   } status_type;

   // Object store port: a read and a write per cycle, read data registered.
   typedef struct packed {
      logic              rd;
      logic              wr;
      logic [ADDR_W-1:0] addr;
      logic [OBJ_W-1:0]  link;
      logic              taken;
   } obj_req_type;

   typedef struct packed {
      logic [OBJ_W-1:0] link;
      logic             taken;
   } obj_rsp_type;
endpackage

// ----- hdl/soa_obj_mem.sv -----
// Object store: free-stack link and taken bit for every object.
// Depends on soa_pkg. Taken bits reset by a clearing pass in soa_ctrl.
module soa_obj_mem
   import soa_pkg::*;
(
   input  logic        clock,
   input  obj_req_type req,
   output obj_rsp_type rsp
);
   logic [OBJ_W:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (req.wr) begin
         mem[req.addr] <= {req.link, req.taken};
      end
      if (req.rd) begin
         {rsp.link, rsp.taken} <= mem[req.addr];
      end
   end
endmodule

// ----- hdl/soa_ctrl.sv -----
// Sequencer for allocate and free: slab table, list links, object store.
// Depends on soa_pkg; drives soa_obj_mem through an obj_req_type port.
module soa_ctrl
   import soa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              kind,
   input  logic [SLAB_W-1:0] slab_in,
   input  logic [OBJ_W-1:0]  object_in,
   input  logic              csr_we,
   input  logic [CAP_W-1:0]  csr_value,
   output logic              busy,
   output logic              done,
   output status_type        status,
   output logic [SLAB_W-1:0] slab_out,
   output logic [OBJ_W-1:0]  object_out,
   output obj_req_type       mreq,
   input  obj_rsp_type       mrsp
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_FIND, S_INIT, S_READ, S_WAIT, S_UPDATE,
      S_REL, S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [SLAB_W-1:0] slab_ff, slab_in2;
   logic [OBJ_W-1:0]  obj_ff, obj_in;
   logic              kind_ff, kind_in;
   status_type        st_ff, st_in;
   logic [CAP_W-1:0]  cap_ff, cap_in;
   logic [OBJ_W:0]    init_ff, init_in;

   logic [NUM_SLABS-1:0] owned_ff, owned_in;
   logic [CNT_W-1:0]  used_ff [NUM_SLABS];
   logic [CNT_W-1:0]  used_in [NUM_SLABS];
   logic [OBJ_W-1:0]  top_ff [NUM_SLABS];
   logic [OBJ_W-1:0]  top_in [NUM_SLABS];
   tag_type           tag_ff [NUM_SLABS];
   tag_type           tag_in [NUM_SLABS];
   logic [LINK_W-1:0] fwd_ff [NUM_SLABS];
   logic [LINK_W-1:0] fwd_in [NUM_SLABS];
   logic [LINK_W-1:0] bwd_ff [NUM_SLABS];
   logic [LINK_W-1:0] bwd_in [NUM_SLABS];
   logic [LINK_W-1:0] head_ff [4];
   logic [LINK_W-1:0] head_in [4];
   logic [SLAB_W:0]   ecnt_ff, ecnt_in;

   logic [OBJ_W:0]    cap;
   logic [SLAB_W-1:0] free_slab;
   logic              free_found;
   logic [CNT_W-1:0]  u;

   always_comb begin
      cap = (cap_ff == '0) ? (OBJ_W+1)'(1) :
            (cap_ff > CAP_W'(MAX_OBJECTS)) ? (OBJ_W+1)'(MAX_OBJECTS) :
            cap_ff[OBJ_W:0];
      free_slab  = '0;
      free_found = 1'b0;
      for (int i = NUM_SLABS-1; i >= 0; i--) begin
         if (!owned_ff[i]) begin
            free_slab  = SLAB_W'(i);
            free_found = 1'b1;
         end
      end
   end

   // List helpers act on the *_in copies so several moves chain in one step.
   function automatic void unlink(input logic [SLAB_W-1:0] s,
                                  ref tag_type t [NUM_SLABS],
                                  ref logic [LINK_W-1:0] f [NUM_SLABS],
                                  ref logic [LINK_W-1:0] b [NUM_SLABS],
                                  ref logic [LINK_W-1:0] h [4]);
      logic [LINK_W-1:0] nf, nb;
      nf = f[s];
      nb = b[s];
      if (t[s] != TAG_NONE) begin
         if (nb != NULL_CODE) f[nb[SLAB_W-1:0]] = nf;
         else h[t[s]] = nf;
         if (nf != NULL_CODE) b[nf[SLAB_W-1:0]] = nb;
         f[s] = NULL_CODE;
         b[s] = NULL_CODE;
         t[s] = TAG_NONE;
      end
   endfunction

   function automatic void push(input logic [SLAB_W-1:0] s, input tag_type tg,
                                ref tag_type t [NUM_SLABS],
                                ref logic [LINK_W-1:0] f [NUM_SLABS],
                                ref logic [LINK_W-1:0] b [NUM_SLABS],
                                ref logic [LINK_W-1:0] h [4]);
      logic [LINK_W-1:0] hd;
      unlink(s, t, f, b, h);
      hd = h[tg];
      f[s] = hd;
      b[s] = NULL_CODE;
      if (hd != NULL_CODE) b[hd[SLAB_W-1:0]] = {1'b0, s};
      h[tg] = {1'b0, s};
      t[s] = tg;
   endfunction

   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      slab_in2 = slab_ff;
      obj_in   = obj_ff;
      kind_in  = kind_ff;
      st_in    = st_ff;
      cap_in   = cap_ff;
      init_in  = init_ff;
      owned_in = owned_ff;
      used_in  = used_ff;
      top_in   = top_ff;
      tag_in   = tag_ff;
      fwd_in   = fwd_ff;
      bwd_in   = bwd_ff;
      head_in  = head_ff;
      ecnt_in  = ecnt_ff;
      mreq     = '0;
      u        = '0;
      if (csr_we && owned_ff == '0) cap_in = csr_value;
      case (state_ff)
         S_CLEAR: begin
            mreq.wr   = 1'b1;
            mreq.addr = addr_ff;
            addr_in   = addr_ff + 1'b1;
            if (addr_ff == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               kind_in  = kind;
               slab_in2 = slab_in;
               obj_in   = object_in;
               state_in = S_FIND;
            end
         end
         S_FIND: begin
            st_in = ST_OK;
            if (!kind_ff) begin
               if (head_ff[TAG_PARTIAL] != NULL_CODE) begin
                  slab_in2 = head_ff[TAG_PARTIAL][SLAB_W-1:0];
                  state_in = S_READ;
               end else if (head_ff[TAG_EMPTY] != NULL_CODE) begin
                  slab_in2 = head_ff[TAG_EMPTY][SLAB_W-1:0];
                  state_in = S_READ;
               end else if (free_found) begin
                  slab_in2 = free_slab;
                  owned_in[free_slab] = 1'b1;
                  used_in[free_slab]  = '0;
                  top_in[free_slab]   = OBJ_W'(cap - 1'b1);
                  push(free_slab, TAG_EMPTY, tag_in, fwd_in, bwd_in, head_in);
                  ecnt_in  = ecnt_ff + 1'b1;
                  init_in  = '0;
                  state_in = S_INIT;
               end else begin
                  st_in    = ST_NOMEM;
                  state_in = S_DONE;
               end
            end else begin
               if (!owned_ff[slab_ff] || {1'b0, obj_ff} >= cap) begin
                  st_in    = ST_NOTFOUND;
                  state_in = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_INIT: begin
            // lay down the free stack, one link a cycle
            mreq.wr   = 1'b1;
            mreq.addr = {slab_ff, init_ff[OBJ_W-1:0]};
            mreq.link = (init_ff == '0) ? '0 : OBJ_W'(init_ff - 1'b1);
            init_in   = init_ff + 1'b1;
            if (init_ff + 1'b1 == cap) state_in = S_READ;
         end
         S_READ: begin
            if (!kind_ff) obj_in = top_ff[slab_ff];
            mreq.rd   = 1'b1;
            mreq.addr = {slab_ff, (kind_ff ? obj_ff : top_ff[slab_ff])};
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            mreq.addr = {slab_ff, obj_ff};
            state_in  = S_DONE;
            if (!kind_ff) begin
               mreq.wr    = 1'b1;
               mreq.link  = mrsp.link;
               mreq.taken = 1'b1;
               top_in[slab_ff] = mrsp.link;
               u = used_ff[slab_ff] + 1'b1;
               used_in[slab_ff] = u;
               if (u >= cap) begin
                  if (tag_ff[slab_ff] == TAG_EMPTY) ecnt_in = ecnt_ff - 1'b1;
                  push(slab_ff, TAG_FULL, tag_in, fwd_in, bwd_in, head_in);
               end else if (u == CNT_W'(1) && tag_ff[slab_ff] == TAG_EMPTY) begin
                  ecnt_in = ecnt_ff - 1'b1;
                  push(slab_ff, TAG_PARTIAL, tag_in, fwd_in, bwd_in, head_in);
               end
            end else if (!mrsp.taken) begin
               st_in = ST_DOUBLE;
            end else begin
               mreq.wr    = 1'b1;
               mreq.link  = top_ff[slab_ff];
               mreq.taken = 1'b0;
               top_in[slab_ff] = obj_ff;
               u = (used_ff[slab_ff] != '0) ? used_ff[slab_ff] - 1'b1 : '0;
               used_in[slab_ff] = u;
               if (u == '0) begin
                  if (tag_ff[slab_ff] != TAG_EMPTY) begin
                     push(slab_ff, TAG_EMPTY, tag_in, fwd_in, bwd_in, head_in);
                     ecnt_in = ecnt_ff + 1'b1;
                  end
                  state_in = S_REL;
               end else if (u == CNT_W'(cap - 1'b1) && tag_ff[slab_ff] == TAG_FULL) begin
                  push(slab_ff, TAG_PARTIAL, tag_in, fwd_in, bwd_in, head_in);
               end
            end
         end
         S_REL: begin
            // release the slab when another empty one remains
            if (ecnt_ff > (SLAB_W+1)'(1)) begin
               unlink(slab_ff, tag_in, fwd_in, bwd_in, head_in);
               owned_in[slab_ff] = 1'b0;
               ecnt_in = ecnt_ff - 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff  <= '0;
         cap_ff   <= CAP_W'(MAX_OBJECTS);
         owned_ff <= '0;
         ecnt_ff  <= '0;
         for (int i = 0; i < NUM_SLABS; i++) begin
            used_ff[i] <= '0;
            tag_ff[i]  <= TAG_NONE;
            fwd_ff[i]  <= NULL_CODE;
            bwd_ff[i]  <= NULL_CODE;
         end
         for (int i = 0; i < 4; i++) head_ff[i] <= NULL_CODE;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         cap_ff   <= cap_in;
         owned_ff <= owned_in;
         ecnt_ff  <= ecnt_in;
         used_ff  <= used_in;
         tag_ff   <= tag_in;
         fwd_ff   <= fwd_in;
         bwd_ff   <= bwd_in;
         head_ff  <= head_in;
      end
      slab_ff <= slab_in2;
      obj_ff  <= obj_in;
      kind_ff <= kind_in;
      st_ff   <= st_in;
      init_ff <= init_in;
      top_ff  <= top_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign done       = (state_ff == S_DONE);
   assign status     = st_ff;
   assign slab_out   = (st_ff == ST_OK && !kind_ff) ? slab_ff : '0;
   assign object_out = (st_ff == ST_OK && !kind_ff) ? obj_ff : '0;
endmodule

// ----- hdl/slab_object_allocator.sv -----
// Channel | dir | payload
// req     | in  | tdata {object_in[10:5], slab_in[4:1], kind[0]}
// rsp     | out | tdata {object_out[11:6], slab_out[5:2], status[1:0]}
// csr     | in  | data  objects_per_slab[6:0]
// Allocate: S_FIND, S_READ, S_WAIT, S_UPDATE, S_DONE; claiming a new slab
// adds S_INIT, writing one link per object. Free: the same states, plus S_REL
// when the slab empties. A bad free target or an exhausted pool goes from
// S_FIND to S_DONE. After reset, clearing all 1024 entries blocks req.
// A result held in the output register blocks the next request.
// Top level; depends on soa_pkg, soa_ctrl, soa_obj_mem.
module slab_object_allocator
   import soa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // kind, slab_in, object_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // status, slab_out, object_out
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data
);
   obj_req_type       mreq;
   obj_rsp_type       mrsp;
   logic              busy, done;
   status_type        status;
   logic [SLAB_W-1:0] slab_out;
   logic [OBJ_W-1:0]  object_out;
   logic              vld_ff;
   logic [11:0]       out_ff;
   logic              start;
   logic              vld_ff_block;

   // hold a new item only while a result would collide in the register
   assign vld_ff_block = vld_ff && !rsp_tready;
   assign req_tready = !busy && !vld_ff_block;
   assign start = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   soa_ctrl u_ctrl (
      .clock, .reset, .start,
      .kind(req_tdata[0]), .slab_in(req_tdata[4:1]), .object_in(req_tdata[10:5]),
      .csr_we(csr_valid), .csr_value(csr_data),
      .busy, .done, .status, .slab_out, .object_out, .mreq, .mrsp
   );

   soa_obj_mem u_mem (.clock, .req(mreq), .rsp(mrsp));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (done) begin
         vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         vld_ff <= 1'b0;
      end
      if (done) out_ff <= {object_out, slab_out, status};
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {4'b0, out_ff};
endmodule

// ----- hdl/soa_checker.sv -----
// Port-level checks for slab_object_allocator, bound to the top level.
// Depends on soa_pkg for the status codes.
module soa_checker
   import soa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ST_OK |-> rsp_tdata[11:2] == '0)
      else $error("nonzero payload on failure");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:12] == '0)
      else $error("pad bits set");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");
endmodule

bind slab_object_allocator soa_checker u_soa_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking bench for slab_object_allocator: directed, random alloc/free beats
// checked against an in-bench allocator model. Depends on soa_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
   import soa_pkg::*;

   localparam int NS = NUM_SLABS;
   localparam int MO = MAX_OBJECTS;

   typedef struct packed {
      logic [OBJ_W-1:0]  obj;
      logic [SLAB_W-1:0] slab;
      logic              kind;
   } op_type;

   typedef struct packed {
      logic [OBJ_W-1:0]  obj;
      logic [SLAB_W-1:0] slab;
      status_type        status;
   } grant_type;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tready;
   logic [15:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic csr_valid = 0, csr_ready;
   logic [6:0] csr_data = '0;

   slab_object_allocator u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial forever #4 clock = ~clock;

   // allocator shadow
   logic [6:0]        m_cap_reg;
   logic              m_owned [NS];
   int                m_used [NS];
   int                m_top [NS];
   int                m_link [NS*MO];
   logic              m_taken [NS*MO];
   tag_type           m_tag [NS];
   int                m_fwd [NS], m_bwd [NS];
   int                m_head [4];
   int                m_nempty;

   op_type    pending_ops [$];
   grant_type grants_due [$];
   int        errors = 0;
   bit        driver_hold = 0;
   int        rx_hold = 0;
   int        hold_req = 0, hold_ack = 0;
   int        n_taken = 0, n_seen = 0;
   bit        calm = 0;

   function automatic int eff_cap();
      int c;
      c = m_cap_reg;
      if (c == 0) c = 1;
      if (c > MO) c = MO;
      return c;
   endfunction

   function automatic void shadow_reset();
      m_cap_reg = 7'd64;
      for (int i = 0; i < NS; i++) begin
         m_owned[i] = 0; m_used[i] = 0; m_top[i] = 0; m_tag[i] = TAG_NONE;
         m_fwd[i] = NS; m_bwd[i] = NS;
      end
      for (int i = 0; i < NS*MO; i++) begin
         m_link[i] = 0; m_taken[i] = 0;
      end
      for (int i = 0; i < 4; i++) m_head[i] = NS;
      m_nempty = 0;
   endfunction

   function automatic void unlink_slab(int s);
      int f, b;
      f = m_fwd[s];
      b = m_bwd[s];
      if (m_tag[s] == TAG_NONE) return;
      if (b < NS) m_fwd[b] = f;
      else m_head[m_tag[s]] = f;
      if (f < NS) m_bwd[f] = b;
      m_fwd[s] = NS; m_bwd[s] = NS; m_tag[s] = TAG_NONE;
   endfunction

   function automatic void push_slab(int s, tag_type t);
      int f;
      unlink_slab(s);
      f = m_head[t];
      m_fwd[s] = f; m_bwd[s] = NS;
      if (f < NS) m_bwd[f] = s;
      m_head[t] = s; m_tag[s] = t;
   endfunction

   function automatic bit any_owned();
      for (int i = 0; i < NS; i++) if (m_owned[i]) return 1;
      return 0;
   endfunction

   function automatic grant_type serve_op(op_type op);
      grant_type g;
      int cap, s, o, a;
      g = '0;
      g.status = ST_OK;
      cap = eff_cap();
      if (op.kind == 1'b0) begin
         if (m_head[TAG_PARTIAL] < NS) s = m_head[TAG_PARTIAL];
         else if (m_head[TAG_EMPTY] < NS) s = m_head[TAG_EMPTY];
         else begin
            for (s = 0; s < NS; s++) if (!m_owned[s]) break;
            if (s >= NS) begin
               g.status = ST_NOMEM;
               return g;
            end
            m_owned[s] = 1; m_used[s] = 0; m_top[s] = cap - 1;
            for (int i = 0; i < cap; i++) m_link[s*MO+i] = (i == 0) ? 0 : i - 1;
            push_slab(s, TAG_EMPTY);
            m_nempty++;
         end
         o = m_top[s];
         a = s*MO + o;
         m_top[s] = m_link[a];
         m_taken[a] = 1;
         m_used[s]++;
         if (m_used[s] >= cap) begin
            if (m_tag[s] == TAG_EMPTY) m_nempty--;
            push_slab(s, TAG_FULL);
         end else if (m_used[s] == 1 && m_tag[s] == TAG_EMPTY) begin
            m_nempty--;
            push_slab(s, TAG_PARTIAL);
         end
         g.slab = SLAB_W'(s);
         g.obj = OBJ_W'(o);
         return g;
      end
      s = op.slab;
      o = op.obj;
      if (!m_owned[s] || o >= cap) begin
         g.status = ST_NOTFOUND;
         return g;
      end
      a = s*MO + o;
      if (!m_taken[a]) begin
         g.status = ST_DOUBLE;
         return g;
      end
      m_taken[a] = 0;
      m_link[a] = m_top[s];
      m_top[s] = o;
      if (m_used[s] > 0) m_used[s]--;
      if (m_used[s] == 0) begin
         if (m_tag[s] != TAG_EMPTY) begin
            push_slab(s, TAG_EMPTY);
            m_nempty++;
         end
         if (m_nempty > 1) begin
            unlink_slab(s);
            m_owned[s] = 0;
            m_nempty--;
         end
      end else if (m_used[s] == cap - 1 && m_tag[s] == TAG_FULL) begin
         push_slab(s, TAG_PARTIAL);
      end
      return g;
   endfunction

   // driver: present beats at the falling edge, predict on acceptance
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         grants_due.push_back(serve_op(pending_ops.pop_front()));
         n_taken++;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || n_taken != n_seen) begin
         // previous beat taken (or none): choose the next one
         n_seen = n_taken;
         if (pending_ops.size() > 0 && !driver_hold &&
             (calm || $urandom_range(99) >= 19)) begin
            req_tvalid <= 1;
            req_tdata  <= {5'd0, pending_ops[0]};
         end else begin
            req_tvalid <= 0;
            req_tdata  <= 16'($urandom);
         end
      end
   end

   // a beat offered at the last negedge is only popped on acceptance, so the
   // queue head is the one being presented while tvalid stays high

   // monitor
   always @(negedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack <= hold_req;
         rx_hold <= 300;
         rsp_tready <= 0;
      end else if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 19);
      end
   end

   always @(posedge clock) begin
      grant_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = grant_type'(rsp_tdata[11:0]);
         if (grants_due.size() == 0) begin
            $display("%0t unexpected result: actual %h", $time, got);
            errors++;
         end else begin
            want = grants_due.pop_front();
            if (got.status !== want.status)
               $display("%0t status: expected %0d actual %0d", $time, want.status, got.status);
            if (got.slab !== want.slab)
               $display("%0t slab_out: expected %0d actual %0d", $time, want.slab, got.slab);
            if (got.obj !== want.obj)
               $display("%0t object_out: expected %0d actual %0d", $time, want.obj, got.obj);
            if (got !== want) errors++;
         end
      end
   end

   function automatic op_type mk_op(bit k, int s, int o);
      op_type op;
      op.kind = k; op.slab = SLAB_W'(s); op.obj = OBJ_W'(o);
      return op;
   endfunction

   task automatic drain();
      while (pending_ops.size() > 0 || grants_due.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_capacity(logic [6:0] v);
      @(negedge clock);
      csr_valid <= 1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (!any_owned()) m_cap_reg = v;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic random_phase(int n, int cap_hint);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         if (k < 50) pending_ops.push_back(mk_op(0, $urandom, $urandom));
         else if (k < 90)
            pending_ops.push_back(mk_op(1, $urandom_range(3), $urandom_range(cap_hint)));
         else pending_ops.push_back(mk_op(1, $urandom, $urandom));
      end
   endtask

   initial begin
      logic [6:0] caps [6] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd3, 7'd8};
      shadow_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: default capacity
      pending_ops.push_back(mk_op(1, 0, 0));            // free in unowned slab
      pending_ops.push_back(mk_op(0, 15, 63));
      pending_ops.push_back(mk_op(0, 0, 0));
      pending_ops.push_back(mk_op(1, 0, 63));
      pending_ops.push_back(mk_op(1, 0, 63));           // double free
      pending_ops.push_back(mk_op(1, 0, 62));
      pending_ops.push_back(mk_op(1, 15, 63));
      drain();
      write_capacity(7'd10);                            // ignored: slab still owned
      pending_ops.push_back(mk_op(1, 0, 0));            // obj 0 of owned slab 0 is free -> double
      drain();
      // capacity write of one is ignored (slab 0 owned): 17 allocs, then frees
      write_capacity(7'd1);
      for (int i = 0; i < 17; i++) pending_ops.push_back(mk_op(0, 0, 0));
      pending_ops.push_back(mk_op(1, 3, 1));            // slab 3 not owned
      for (int i = 0; i < 16; i++) pending_ops.push_back(mk_op(1, i, 0));
      drain();
      // random phases per capacity write; in the second, a long receiver hold-off while sender keeps offering
      for (int c = 0; c < 6; c++) begin
         write_capacity(caps[c]);
         if (c == 1) hold_req++;
         calm = (c == 4);
         random_phase(50, (c == 0 || c == 3) ? 63 : 9);
         // free all still held; one empty slab stays owned, so the next write is ignored
         drain();
         driver_hold = 1;
         for (int s = 0; s < NS; s++)
            for (int o = 0; o < MO; o++)
               if (m_taken[s*MO+o]) pending_ops.push_back(mk_op(1, s, o));
         driver_hold = 0;
         drain();
      end
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

   initial begin
      #3000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
